// File: hw/rtl/yds_pkg.sv
// yds_pkg: shared types and constants of the yuy2 downscaler and quantizer
// no dependencies; imported by the lane, the merge stage and the top level
`default_nettype none

package yds_pkg;

    // configuration register indexes (word addresses on the apb port)
    localparam int unsigned APB_AW = 4;
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_QUANT_GAIN   = 2'd2;
    localparam logic [1:0] CFG_QUANT_ZP     = 2'd3;

    localparam logic [10:0] RST_FRAME_WIDTH  = 11'd160;
    localparam logic [10:0] RST_FRAME_HEIGHT = 11'd120;
    localparam logic [15:0] RST_QUANT_GAIN   = 16'd4096;
    localparam logic signed [7:0] RST_QUANT_ZP = -8'sd128;

    // bt.601 integer coefficients
    localparam logic signed [19:0] K_Y    = 20'sd298;
    localparam logic signed [19:0] K_RV   = 20'sd409;
    localparam logic signed [19:0] K_GU   = 20'sd100;
    localparam logic signed [19:0] K_GV   = 20'sd208;
    localparam logic signed [19:0] K_BU   = 20'sd516;
    localparam logic signed [19:0] K_RND  = 20'sd128;
    localparam logic signed [9:0]  Y_OFS  = 10'sd16;
    localparam logic signed [9:0]  C_OFS  = 10'sd128;
    localparam logic [7:0]         CH_MAX = 8'd255;
    localparam logic signed [12:0] Q_MIN  = -13'sd128;
    localparam logic signed [12:0] Q_MAX  = 13'sd127;

    typedef struct packed {
        logic signed [7:0] red;
        logic signed [7:0] green;
        logic signed [7:0] blue;
    } t_rgb_q;

    typedef struct packed {
        logic s2_en;
        logic s3_en;
    } t_lane_en;

    // picks, coordinates and frame-end flags of the two pixels of one macropixel
    typedef struct packed {
        logic [1:0] pick;
        logic [5:0] col0;
        logic [5:0] col1;
        logic [5:0] row;
        logic [1:0] fe;
    } t_meta;

    typedef struct packed {
        logic signed [7:0] red_q;
        logic signed [7:0] green_q;
        logic signed [7:0] blue_q;
        logic [5:0]        out_col;
        logic [5:0]        out_row;
        logic              frame_end;
        logic              last;
    } t_res;

endpackage

`default_nettype wire

// File: hw/rtl/yds_pix_if.sv
// yds_pix_if: input channel carrying one yuy2 macropixel per item
// no dependencies
`default_nettype none

interface yds_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_even;
    logic [7:0] chroma_u;
    logic [7:0] luma_odd;
    logic [7:0] chroma_v;
    logic       frame_start;

    modport source(output valid, output luma_even, output chroma_u, output luma_odd,
                   output chroma_v, output frame_start, input ready);
    modport sink(input valid, input luma_even, input chroma_u, input luma_odd,
                 input chroma_v, input frame_start, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/yds_res_if.sv
// yds_res_if: output channel carrying one quantized rgb pixel per item
// no dependencies
`default_nettype none

interface yds_res_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] red_q;
    logic signed [7:0] green_q;
    logic signed [7:0] blue_q;
    logic [5:0]        out_col;
    logic [5:0]        out_row;
    logic              frame_end;
    logic              last;

    modport source(output valid, output red_q, output green_q, output blue_q,
                   output out_col, output out_row, output frame_end, output last,
                   input ready);
    modport sink(input valid, input red_q, input green_q, input blue_q,
                 input out_col, input out_row, input frame_end, input last,
                 output ready);
endinterface

`default_nettype wire

// File: hw/rtl/yuy2_downscale_rgb_quantizer.sv
// yuy2_downscale_rgb_quantizer: top level, apb registers, pick logic and pipeline control
// depends on yds_pkg, yds_pix_if, yds_res_if, yds_lane and yds_merge
//
// Takes a yuy2 frame in raster order, one macropixel (Y0 U Y1 V) per item, and emits an
// OUT_SIZE x OUT_SIZE nearest-neighbour decimation of it as quantized signed 8-bit rgb.
// A macropixel is accepted every clock cycle unless the pipe stalls; the pick decision
// for both of its pixels is made in the accept cycle from running row and column
// accumulators, and two lanes convert the even and odd pixel side by side. A picked
// pixel passes the input, rgb and gain product registers and a merge slot. The merge
// stage holds up to two results and drives one per cycle while the output is ready;
// the input holds off while items picking both pixels arrive faster than the output
// drains them. frame_start on an item clears all counters before that item is handled.
// Registers (apb, word addresses): 0 frame_width, 1 frame_height, 2 quant_gain (Q4.12),
// 3 quantization offset; write them only while the block is idle.
`default_nettype none

module yuy2_downscale_rgb_quantizer #(
    parameter int unsigned OUT_SIZE = 48
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    yds_pix_if.sink                          i_pix,
    yds_res_if.source                        o_res,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [yds_pkg::APB_AW-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import yds_pkg::*;

    localparam int unsigned DC_W  = $clog2(OUT_SIZE + 1);
    localparam int unsigned ACC_W = $clog2(4100 * OUT_SIZE + 8192);
    localparam logic [ACC_W-1:0] OUT_A  = ACC_W'(OUT_SIZE);
    localparam logic [ACC_W-1:0] OUT_A2 = ACC_W'(2 * OUT_SIZE);
    localparam logic [DC_W-1:0]  OUT_D  = DC_W'(OUT_SIZE);
    localparam logic [DC_W-1:0]  LAST_D = DC_W'(OUT_SIZE - 1);

    // configuration
    logic [10:0]       r_fw, r_fh;
    logic [15:0]       r_gain;
    logic signed [7:0] r_zp;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw   <= RST_FRAME_WIDTH;
            r_fh   <= RST_FRAME_HEIGHT;
            r_gain <= RST_QUANT_GAIN;
            r_zp   <= RST_QUANT_ZP;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                CFG_FRAME_WIDTH:  r_fw   <= pwdata[10:0];
                CFG_FRAME_HEIGHT: r_fh   <= pwdata[10:0];
                CFG_QUANT_GAIN:   r_gain <= pwdata[15:0];
                CFG_QUANT_ZP:     r_zp   <= $signed(pwdata[7:0]);
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            CFG_FRAME_WIDTH:  prdata = {21'd0, r_fw};
            CFG_FRAME_HEIGHT: prdata = {21'd0, r_fh};
            CFG_QUANT_GAIN:   prdata = {16'd0, r_gain};
            CFG_QUANT_ZP:     prdata = {24'd0, r_zp};
        endcase
    end

    // position state; the limits hold (source index + 1) * OUT_SIZE
    logic [10:0]      r_src_col, r_src_row, n_src_col, n_src_row;
    logic [DC_W-1:0]  r_dst_col, r_dst_row, n_dst_col, n_dst_row;
    logic [ACC_W-1:0] r_col_acc, r_row_acc, n_col_acc, n_row_acc;
    logic [ACC_W-1:0] r_col_lim, r_row_lim, n_col_lim, n_row_lim;

    logic [10:0]      e_sc, e_sr;
    logic [DC_W-1:0]  e_dc, e_dr, dc1;
    logic [ACC_W-1:0] e_cacc, e_racc, e_clim, e_rlim, cacc1, fw_a, fh_a;
    logic [11:0]      col0, col1, fw12;
    logic             fs, row_used, pick0, pick1, row_end;

    // pipeline control
    logic  r_v1, r_v2, r_v3;
    logic  adv1, adv2, adv3, take, in_fire;
    t_meta r_m1, r_m2, r_m3, n_meta;
    logic [7:0] r_y0, r_y1, r_u, r_v;
    t_lane_en   lane_en;
    t_rgb_q     q0, q1;

    assign fs     = i_pix.frame_start;
    assign e_sc   = fs ? 11'd0 : r_src_col;
    assign e_sr   = fs ? 11'd0 : r_src_row;
    assign e_dc   = fs ? '0 : r_dst_col;
    assign e_dr   = fs ? '0 : r_dst_row;
    assign e_cacc = fs ? '0 : r_col_acc;
    assign e_racc = fs ? '0 : r_row_acc;
    assign e_clim = fs ? OUT_A : r_col_lim;
    assign e_rlim = fs ? OUT_A : r_row_lim;
    assign fw_a   = ACC_W'(r_fw);
    assign fh_a   = ACC_W'(r_fh);
    assign fw12   = {1'b0, r_fw};
    assign col0   = {1'b0, e_sc};
    assign col1   = col0 + 12'd1;

    assign row_used = (e_dr < OUT_D) && (e_racc < e_rlim);
    assign pick0    = row_used && (col0 < fw12) && (e_dc < OUT_D) && (e_cacc < e_clim);
    assign dc1      = e_dc + DC_W'(pick0);
    assign cacc1    = pick0 ? e_cacc + fw_a : e_cacc;
    assign pick1    = row_used && (col1 < fw12) && (dc1 < OUT_D)
                      && (cacc1 < e_clim + OUT_A);
    assign row_end  = (col0 + 12'd2) >= fw12;

    always_comb begin
        n_src_row = e_sr;
        n_row_lim = e_rlim;
        n_dst_row = e_dr;
        n_row_acc = e_racc;
        if (row_end) begin
            n_src_col = 11'd0;
            n_dst_col = '0;
            n_col_acc = '0;
            n_col_lim = OUT_A;
            n_src_row = e_sr + 11'd1;
            n_row_lim = (e_sr == 11'h7FF) ? OUT_A : e_rlim + OUT_A;
            if (row_used) begin
                n_dst_row = e_dr + DC_W'(1);
                n_row_acc = e_racc + fh_a;
            end
        end else begin
            n_src_col = e_sc + 11'd2;
            n_dst_col = dc1 + DC_W'(pick1);
            n_col_acc = pick1 ? cacc1 + fw_a : cacc1;
            n_col_lim = e_clim + OUT_A2;
        end
    end

    always_comb begin
        n_meta.pick = {pick1, pick0};
        n_meta.col0 = 6'(e_dc);
        n_meta.col1 = 6'(dc1);
        n_meta.row  = 6'(e_dr);
        n_meta.fe   = {(e_dr == LAST_D) && (dc1 == LAST_D),
                       (e_dr == LAST_D) && (e_dc == LAST_D)};
    end

    assign adv3        = !r_v3 || take;
    assign adv2        = !r_v2 || adv3;
    assign adv1        = !r_v1 || adv2;
    assign i_pix.ready = adv1;
    assign in_fire     = i_pix.valid && adv1;
    assign lane_en     = '{s2_en: adv2, s3_en: adv3};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col <= 11'd0;
            r_src_row <= 11'd0;
            r_dst_col <= '0;
            r_dst_row <= '0;
            r_col_acc <= '0;
            r_row_acc <= '0;
            r_col_lim <= OUT_A;
            r_row_lim <= OUT_A;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
        end else begin
            if (in_fire) begin
                r_src_col <= n_src_col;
                r_src_row <= n_src_row;
                r_dst_col <= n_dst_col;
                r_dst_row <= n_dst_row;
                r_col_acc <= n_col_acc;
                r_row_acc <= n_row_acc;
                r_col_lim <= n_col_lim;
                r_row_lim <= n_row_lim;
            end
            // items that pick nothing never enter the pipe
            if (adv1) r_v1 <= in_fire && (pick0 || pick1);
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_m1 <= n_meta;
            r_y0 <= i_pix.luma_even;
            r_y1 <= i_pix.luma_odd;
            r_u  <= i_pix.chroma_u;
            r_v  <= i_pix.chroma_v;
        end
        if (adv2) r_m2 <= r_m1;
        if (adv3) r_m3 <= r_m2;
    end

    yds_lane u_lane0 (
        .i_clk  (i_clk),
        .i_en   (lane_en),
        .i_luma (r_y0),
        .i_cb   (r_u),
        .i_cr   (r_v),
        .i_gain (r_gain),
        .i_zp   (r_zp),
        .o_q    (q0)
    );

    yds_lane u_lane1 (
        .i_clk  (i_clk),
        .i_en   (lane_en),
        .i_luma (r_y1),
        .i_cb   (r_u),
        .i_cr   (r_v),
        .i_gain (r_gain),
        .i_zp   (r_zp),
        .o_q    (q1)
    );

    yds_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_meta  (r_m3),
        .i_q0    (q0),
        .i_q1    (q1),
        .o_take  (take),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// File: hw/rtl/yds_lane.sv
// yds_lane: one pixel lane, yuv to clamped rgb, then gain, zero point and saturation
// depends on yds_pkg
`default_nettype none

module yds_lane (
    input  wire logic              i_clk,
    input  wire yds_pkg::t_lane_en i_en,
    input  wire logic [7:0]        i_luma,
    input  wire logic [7:0]        i_cb,
    input  wire logic [7:0]        i_cr,
    input  wire logic [15:0]       i_gain,
    input  wire logic signed [7:0] i_zp,
    output yds_pkg::t_rgb_q        o_q
);
    import yds_pkg::*;

    logic signed [9:0]  c, d, e;
    logic signed [19:0] c20, d20, e20;
    logic signed [19:0] sum_r, sum_g, sum_b;
    logic [7:0]         n_r, n_g, n_b;
    logic [7:0]         r_r, r_g, r_b;
    logic [23:0]        r_pr, r_pg, r_pb;

    function automatic logic [7:0] clamp_byte(input logic signed [19:0] t);
        logic [7:0] v;
        if (t < 0) begin
            v = 8'd0;
        end else if (t[19:16] != 4'd0) begin
            v = CH_MAX;
        end else begin
            v = t[15:8];
        end
        return v;
    endfunction

    // scaled channel reaches 4079, so the sum with the zero point needs 14 bits
    function automatic logic signed [7:0] sat_q(input logic [23:0] p,
                                               input logic signed [7:0] zp);
        logic signed [13:0] q;
        logic signed [7:0]  v;
        q = $signed({2'b00, p[23:12]}) + $signed({{6{zp[7]}}, zp});
        if (q < Q_MIN) begin
            v = Q_MIN[7:0];
        end else if (q > Q_MAX) begin
            v = Q_MAX[7:0];
        end else begin
            v = q[7:0];
        end
        return v;
    endfunction

    assign c   = $signed({2'b00, i_luma}) - Y_OFS;
    assign d   = $signed({2'b00, i_cb}) - C_OFS;
    assign e   = $signed({2'b00, i_cr}) - C_OFS;
    assign c20 = {{10{c[9]}}, c};
    assign d20 = {{10{d[9]}}, d};
    assign e20 = {{10{e[9]}}, e};

    assign sum_r = c20 * K_Y + e20 * K_RV + K_RND;
    assign sum_g = c20 * K_Y - d20 * K_GU - e20 * K_GV + K_RND;
    assign sum_b = c20 * K_Y + d20 * K_BU + K_RND;

    assign n_r = clamp_byte(sum_r);
    assign n_g = clamp_byte(sum_g);
    assign n_b = clamp_byte(sum_b);

    always_ff @(posedge i_clk) begin
        if (i_en.s2_en) begin
            r_r <= n_r;
            r_g <= n_g;
            r_b <= n_b;
        end
        if (i_en.s3_en) begin
            r_pr <= {16'd0, r_r} * {8'd0, i_gain};
            r_pg <= {16'd0, r_g} * {8'd0, i_gain};
            r_pb <= {16'd0, r_b} * {8'd0, i_gain};
        end
    end

    assign o_q.red   = sat_q(r_pr, i_zp);
    assign o_q.green = sat_q(r_pg, i_zp);
    assign o_q.blue  = sat_q(r_pb, i_zp);

endmodule

`default_nettype wire

// File: hw/rtl/yds_merge.sv
// yds_merge: folds the results of both lanes into one ordered output stream
// depends on yds_pkg and yds_res_if
`default_nettype none

module yds_merge (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire yds_pkg::t_meta i_meta,
    input  wire yds_pkg::t_rgb_q i_q0,
    input  wire yds_pkg::t_rgb_q i_q1,
    output logic                o_take,
    yds_res_if.source           o_res
);
    import yds_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    t_res       r_slot0, r_slot1, n_slot0, n_slot1;
    t_res       res0, res1;
    logic       fire;

    assign res0 = '{red_q: i_q0.red, green_q: i_q0.green, blue_q: i_q0.blue,
                    out_col: i_meta.col0, out_row: i_meta.row,
                    frame_end: i_meta.fe[0], last: !i_meta.pick[1]};
    assign res1 = '{red_q: i_q1.red, green_q: i_q1.green, blue_q: i_q1.blue,
                    out_col: i_meta.col1, out_row: i_meta.row,
                    frame_end: i_meta.fe[1], last: 1'b1};

    assign fire   = o_res.valid && o_res.ready;
    assign o_take = i_valid && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && fire));

    always_comb begin
        n_cnt   = r_cnt;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (o_take) begin
            priority if (i_meta.pick == 2'b11) begin
                n_slot0 = res0;
                n_slot1 = res1;
                n_cnt   = 2'd2;
            end else if (i_meta.pick[0]) begin
                n_slot0 = res0;
                n_cnt   = 2'd1;
            end else begin
                n_slot0 = res1;
                n_cnt   = 2'd1;
            end
        end else if (fire) begin
            n_slot0 = r_slot1;
            n_cnt   = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_res.valid     = (r_cnt != 2'd0);
    assign o_res.red_q     = r_slot0.red_q;
    assign o_res.green_q   = r_slot0.green_q;
    assign o_res.blue_q    = r_slot0.blue_q;
    assign o_res.out_col   = r_slot0.out_col;
    assign o_res.out_row   = r_slot0.out_row;
    assign o_res.frame_end = r_slot0.frame_end;
    assign o_res.last      = r_slot0.last;

endmodule

`default_nettype wire
